### src/cholesky_factor_forward_solve_assert.svh
// Assertion helpers for the factor/solve block.
// Both expect clk and arst_n in the enclosing scope.
`ifndef CHOLESKY_FACTOR_FORWARD_SOLVE_ASSERT_SVH
`define CHOLESKY_FACTOR_FORWARD_SOLVE_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define CFF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CFF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cff_pkg.sv
`timescale 1ns / 1ps
package cff_pkg;

	// result of a multi-cycle arithmetic unit, done is a one-cycle pulse
	typedef struct packed {
		logic        done;
		logic        sat;
		logic [31:0] value;
	} unit_res_t;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_NPD = 2'd1;
	localparam logic [1:0] STATUS_SAT = 2'd2;

	// ln 2 in Q0.24
	localparam logic [23:0] LN2_Q24 = 24'd11629080;

	localparam logic signed [63:0] S32_MAX64 = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN64 = 64'shFFFF_FFFF_8000_0000;

endpackage

### src/cff_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// truncated toward zero, saturated to 32 bits. den must be positive.
module cff_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic        [31:0] den,
	output cff_pkg::unit_res_t res
);
	import cff_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [NW-1:0] dvd_q;
	logic [32:0]   rem_q;
	logic [31:0]   den_q;

	logic [31:0] mag;
	logic [32:0] rem_sh;
	logic        ge;

	assign mag    = num[31] ? 32'(-num) : 32'(num);
	assign rem_sh = {rem_q[31:0], dvd_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= NW'(mag) << FRAC_BITS;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[31];
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			dvd_q <= {dvd_q[NW-2:0], ge};
		end
	end

	logic ovf_pos, ovf_neg;
	assign ovf_pos = !neg_q && (dvd_q > NW'(64'h7FFF_FFFF));
	assign ovf_neg = neg_q && (dvd_q > NW'(64'h8000_0000));

	always_comb begin
		res.done = done_q;
		res.sat  = ovf_pos || ovf_neg;
		if (ovf_pos)
			res.value = 32'h7FFF_FFFF;
		else if (ovf_neg)
			res.value = 32'h8000_0000;
		else if (neg_q)
			res.value = 32'(-dvd_q);
		else
			res.value = dvd_q[31:0];
	end

endmodule

### src/cff_sqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root of (a << FRAC_BITS), one root bit per cycle.
module cff_sqrt #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [30:0]        a,
	output cff_pkg::unit_res_t res
);
	import cff_pkg::*;

	localparam int RW = ((32 + FRAC_BITS) / 2) * 2;
	localparam int HW = RW / 2;
	localparam int CW = $clog2(HW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rad_q;
	logic [HW-1:0] root_q;
	logic [HW+1:0] rem_q;

	logic [HW+3:0] rem_n;
	logic [HW+3:0] trial;
	logic          ge;

	assign rem_n = {rem_q, rad_q[RW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(HW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RW'(a) << FRAC_BITS;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= (HW+2)'(ge ? rem_n - trial : rem_n);
			root_q <= {root_q[HW-2:0], ge};
			rad_q  <= rad_q << 2;
		end
	end

	assign res.done  = done_q;
	assign res.sat   = 1'b0;
	assign res.value = 32'(root_q);

endmodule

### src/cff_ln.sv
`timescale 1ns / 1ps
// Natural log of a positive fixed-point value: normalize one bit per cycle,
// log2 fraction by repeated squaring, then scale by ln 2.
module cff_ln #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [30:0]                 y,
	output logic                        done,
	output logic signed [FRAC_BITS+6:0] ln
);
	import cff_pkg::*;

	localparam int LW = FRAC_BITS + 7;
	localparam int PW = LW + 25;
	localparam int CW = $clog2(FRAC_BITS + 1);

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_NORM = 2'd1;
	localparam logic [1:0] L_SQ   = 2'd2;
	localparam logic [1:0] L_MUL  = 2'd3;

	logic [1:0]           st_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [30:0]          m_q;
	logic [4:0]           p_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic signed [PW-1:0] prod_q;

	logic [61:0]          sq;
	logic [31:0]          t;
	logic signed [6:0]    pf;
	logic signed [LW-1:0] lg;

	assign sq = 62'(m_q) * 62'(m_q);
	assign t  = sq[61:30];
	assign pf = $signed({2'b00, p_q}) - 7'(FRAC_BITS);
	assign lg = $signed({pf, frac_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (st_q == L_MUL);
			unique case (st_q)
				L_IDLE: if (start) st_q <= L_NORM;
				L_NORM: begin
					if (m_q[30]) begin
						st_q  <= L_SQ;
						cnt_q <= CW'(FRAC_BITS);
					end
				end
				L_SQ: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1))
						st_q <= L_MUL;
				end
				L_MUL: st_q <= L_IDLE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && st_q == L_IDLE) begin
			m_q <= y;
			p_q <= 5'd30;
		end else if (st_q == L_NORM && !m_q[30]) begin
			m_q <= m_q << 1;
			p_q <= p_q - 5'd1;
		end else if (st_q == L_SQ) begin
			m_q    <= t[31] ? t[31:1] : t[30:0];
			frac_q <= {frac_q[FRAC_BITS-2:0], t[31]};
		end
		if (st_q == L_MUL)
			prod_q <= PW'(lg) * PW'($signed({1'b0, LN2_Q24}));
	end

	assign done = done_q;
	assign ln   = LW'(prod_q >>> 24);

endmodule

### src/cholesky_factor_forward_solve.sv
`timescale 1ns / 1ps
// Cholesky factor and forward solve, signed fixed point (FRAC_BITS fraction bits).
// Load channel (load_valid/load_stall): one item writes a matrix entry (func 0;
// only the lower triangle is read) or a right-hand vector element (func 1). Load
// items are taken one per cycle while the block is idle. The item with last set
// is written, then the block factors the matrix, solves L x = v and emits
// x(0..n-1) on the result channel (result_valid/result_stall), one item per
// element, each carrying log_det. load_stall stays high from the last item until
// the final result is taken. After the last item the block works through
// n(n+1)/2 factor elements, then n solve elements. Each runs a dot product, one
// product per cycle (from the dual-read factor memory while factoring), then the
// serial divider; a diagonal element uses the serial root instead, then the ln
// unit. Each result is read, then loaded into the result register. A non-positive
// pivot ends the run with one result flagged status 1. A stalled result holds
// its register; nothing advances until it is taken. Reset: order register goes
// to 16, control idles, memories keep old data. The user must write matrix_size
// through cfg_we/cfg_wdata only while the block is idle, which is not enforced.
`include "cholesky_factor_forward_solve_assert.svh"
module cholesky_factor_forward_solve #(
	parameter int MAX_ORDER = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	input  logic               load_valid,
	output logic               load_stall,
	input  logic               func,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [3:0]         index,
	output logic signed [31:0] solution,
	output logic signed [31:0] log_det,
	output logic [1:0]         status,
	output logic               last_result
);
	import cff_pkg::*;

	localparam int ORDER_CAP = (MAX_ORDER < 16) ? MAX_ORDER : 16;
	localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
	localparam int MAW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VAW       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int LNW       = FRAC_BITS + 7;
	localparam int LDW       = (FRAC_BITS + 12 > 33) ? FRAC_BITS + 12 : 33;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_BASE = 4'd1;  // read base term and divisor
	localparam logic [3:0] ST_DOT  = 4'd2;  // stream products into accumulator
	localparam logic [3:0] ST_FIN  = 4'd3;  // saturate, pivot check, launch unit
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_SQRT = 4'd5;
	localparam logic [3:0] ST_LN   = 4'd6;
	localparam logic [3:0] ST_EMRD = 4'd7;  // read x(i)
	localparam logic [3:0] ST_EMLD = 4'd8;  // load result register
	localparam logic [3:0] ST_EMWT = 4'd9;  // hold result until taken

	function automatic logic [MAW-1:0] maddr(input logic [3:0] r, input logic [3:0] c);
		maddr = MAW'(int'(r) * MAX_ORDER + int'(c));
	endfunction

	// ---------------------------------------------------------------- control regs
	logic [3:0] state_q;
	logic [4:0] ms_q;
	logic [4:0] n_q;
	logic [3:0] i_q, j_q, k_q;
	logic       solve_q;   // 0: factor phase, 1: forward substitution
	logic       sat_q;
	logic       base_s1, iss_s1, prod_v_s2;
	logic       result_valid_q;

	// ---------------------------------------------------------------- datapath regs
	logic signed [63:0]  acc_q;
	logic signed [31:0]  dvs_q;
	logic signed [63:0]  prod_s2;
	logic signed [LDW-1:0] logdet_q;
	logic [3:0]          index_q;
	logic signed [31:0]  solution_q, log_det_q;
	logic [1:0]          status_q;
	logic                last_result_q;

	// ---------------------------------------------------------------- memories
	logic signed [31:0] mat_mem [DEPTH];
	logic signed [31:0] fac_mem [DEPTH];
	logic signed [31:0] rhs_mem [MAX_ORDER];
	logic signed [31:0] sol_mem [MAX_ORDER];
	logic signed [31:0] mat_rd_q, fa_rd_q, fb_rd_q, rhs_rd_q, sol_rd_q;

	logic           load_acc;
	logic           mat_we, rhs_we, fac_we, sol_we;
	logic [MAW-1:0] mat_wa, mat_ra, fa_ra, fb_ra, fac_wa;
	logic [VAW-1:0] rhs_wa, rhs_ra, sol_ra, sol_wa;
	logic signed [31:0] fac_wd;

	unit_res_t div_res, sq_res;
	logic      div_start, sq_start, ln_start, ln_done;
	logic signed [LNW-1:0] ln_val;

	logic [4:0] n_eff;
	logic [3:0] kmax;
	logic       is_diag, last_i;
	logic       acc_hi, acc_lo, acc_ovf, acc_npos;
	logic signed [31:0] acc_sat;
	logic       ld_hi, ld_lo, ld_ovf;
	logic signed [31:0] ld32;
	logic signed [31:0] b_op;
	logic signed [63:0] prod_full;

	assign load_stall = (state_q != ST_IDLE);
	assign load_acc   = load_valid && !load_stall;

	assign n_eff = (ms_q == 5'd0) ? 5'd1 :
	               (ms_q > 5'(ORDER_CAP)) ? 5'(ORDER_CAP) : ms_q;
	assign kmax    = solve_q ? i_q : j_q;
	assign is_diag = !solve_q && (j_q == i_q);
	assign last_i  = (5'(i_q) + 5'd1 == n_q);

	// exact sum saturated to 32 bits
	assign acc_hi   = acc_q > S32_MAX64;
	assign acc_lo   = acc_q < S32_MIN64;
	assign acc_ovf  = acc_hi || acc_lo;
	assign acc_npos = acc_q[63] || (acc_q == '0);
	assign acc_sat  = acc_hi ? 32'sh7FFF_FFFF : acc_lo ? 32'sh8000_0000 : acc_q[31:0];

	assign ld_hi  = logdet_q > LDW'(S32_MAX64);
	assign ld_lo  = logdet_q < LDW'(S32_MIN64);
	assign ld_ovf = ld_hi || ld_lo;
	assign ld32   = ld_hi ? 32'sh7FFF_FFFF : ld_lo ? 32'sh8000_0000 : logdet_q[31:0];

	// load writes
	assign mat_we = load_acc && !func && (int'(row) < MAX_ORDER) && (int'(col) < MAX_ORDER);
	assign mat_wa = maddr(row, col);
	assign rhs_we = load_acc && func && (int'(row) < MAX_ORDER);
	assign rhs_wa = VAW'(row);

	// read addresses; every read is registered and its data arrive in the next cycle
	assign mat_ra = maddr(i_q, j_q);
	assign rhs_ra = VAW'(i_q);
	assign fa_ra  = maddr(i_q, k_q);
	assign fb_ra  = (state_q == ST_BASE) ? (solve_q ? maddr(i_q, i_q) : maddr(j_q, j_q))
	                                     : maddr(j_q, k_q);
	assign sol_ra = (state_q == ST_DOT) ? VAW'(k_q) : VAW'(i_q);

	// write back: L(i,j) from divider or root, x(i) from divider.
	// Elements are finished one at a time, so a read never meets a pending write.
	assign fac_we = (state_q == ST_DIV && div_res.done && !solve_q) ||
	                (state_q == ST_SQRT && sq_res.done);
	assign fac_wa = maddr(i_q, j_q);
	assign fac_wd = (state_q == ST_DIV) ? div_res.value : sq_res.value;
	assign sol_we = (state_q == ST_DIV) && div_res.done && solve_q;
	assign sol_wa = VAW'(i_q);

	always_ff @(posedge clk) begin
		if (mat_we)
			mat_mem[mat_wa] <= value;
		mat_rd_q <= mat_mem[mat_ra];
	end

	always_ff @(posedge clk) begin
		if (rhs_we)
			rhs_mem[rhs_wa] <= value;
		rhs_rd_q <= rhs_mem[rhs_ra];
	end

	always_ff @(posedge clk) begin
		if (fac_we)
			fac_mem[fac_wa] <= fac_wd;
		fa_rd_q <= fac_mem[fa_ra];
		fb_rd_q <= fac_mem[fb_ra];
	end

	always_ff @(posedge clk) begin
		if (sol_we)
			sol_mem[sol_wa] <= div_res.value;
		sol_rd_q <= sol_mem[sol_ra];
	end

	// ---------------------------------------------------------------- units
	assign div_start = (state_q == ST_FIN) && !is_diag;
	assign sq_start  = (state_q == ST_FIN) && is_diag && !acc_npos;
	assign ln_start  = (state_q == ST_SQRT) && sq_res.done;

	cff_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_sat),
		.den    (dvs_q),
		.res    (div_res)
	);

	cff_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.a      (acc_sat[30:0]),
		.res    (sq_res)
	);

	cff_ln #(.FRAC_BITS(FRAC_BITS)) u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start),
		.y      (sq_res.value[30:0]),
		.done   (ln_done),
		.ln     (ln_val)
	);

	// product stage: L(i,k) * L(j,k) while factoring, L(i,k) * x(k) while solving
	assign b_op      = solve_q ? sol_rd_q : fb_rd_q;
	assign prod_full = 64'(fa_rd_q) * 64'(b_op);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ms_q           <= 5'd16;
			n_q            <= 5'd1;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			solve_q        <= 1'b0;
			sat_q          <= 1'b0;
			base_s1        <= 1'b0;
			iss_s1         <= 1'b0;
			prod_v_s2      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				ms_q <= cfg_wdata;
			base_s1   <= (state_q == ST_BASE);
			iss_s1    <= (state_q == ST_DOT) && (k_q < kmax);
			prod_v_s2 <= iss_s1;

			unique case (state_q)
				ST_IDLE: begin
					if (load_acc && last) begin
						n_q     <= n_eff;
						i_q     <= '0;
						j_q     <= '0;
						solve_q <= 1'b0;
						sat_q   <= 1'b0;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					k_q     <= '0;
					state_q <= ST_DOT;
				end
				ST_DOT: begin
					if (k_q < kmax)
						k_q <= k_q + 4'd1;
					else if (!iss_s1 && !prod_v_s2 && !base_s1)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (is_diag && acc_npos) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_EMWT;
					end else begin
						sat_q   <= sat_q | acc_ovf;
						state_q <= is_diag ? ST_SQRT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						sat_q <= sat_q | div_res.sat | (solve_q && last_i && ld_ovf);
						if (solve_q) begin
							if (last_i) begin
								i_q     <= '0;
								state_q <= ST_EMRD;
							end else begin
								i_q     <= i_q + 4'd1;
								state_q <= ST_BASE;
							end
						end else begin
							j_q     <= j_q + 4'd1;
							state_q <= ST_BASE;
						end
					end
				end
				ST_SQRT: begin
					if (sq_res.done)
						state_q <= ST_LN;
				end
				ST_LN: begin
					if (ln_done) begin
						if (last_i) begin
							solve_q <= 1'b1;
							i_q     <= '0;
						end else begin
							i_q <= i_q + 4'd1;
						end
						j_q     <= '0;
						state_q <= ST_BASE;
					end
				end
				ST_EMRD: state_q <= ST_EMLD;
				ST_EMLD: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_EMWT;
				end
				ST_EMWT: begin
					if (!result_stall) begin
						result_valid_q <= 1'b0;
						if (last_result_q) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 4'd1;
							state_q <= ST_EMRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (base_s1) begin
			acc_q <= solve_q ? 64'(rhs_rd_q) : 64'(mat_rd_q);
			dvs_q <= fb_rd_q;
		end else if (prod_v_s2) begin
			acc_q <= acc_q - prod_s2;
		end
		prod_s2 <= prod_full >>> FRAC_BITS;   // floor of the scaled product

		if (state_q == ST_IDLE)
			logdet_q <= '0;
		else if (ln_done)
			logdet_q <= logdet_q + LDW'(ln_val);

		if (state_q == ST_FIN && is_diag && acc_npos) begin
			index_q       <= i_q;
			solution_q    <= '0;
			log_det_q     <= '0;
			status_q      <= STATUS_NPD;
			last_result_q <= 1'b1;
		end else if (state_q == ST_EMLD) begin
			index_q       <= i_q;
			solution_q    <= sol_rd_q;
			log_det_q     <= ld32;
			status_q      <= sat_q ? STATUS_SAT : STATUS_OK;
			last_result_q <= last_i;
		end
	end

	assign result_valid = result_valid_q;
	assign index        = index_q;
	assign solution     = solution_q;
	assign log_det      = log_det_q;
	assign status       = status_q;
	assign last_result  = last_result_q;

	// ---------------------------------------------------------------- assertions
	`CFF_ASSERT_NOW(a_no_load_with_result, load_valid && !load_stall, !result_valid, "load taken while a result is pending")
	`CFF_ASSERT_NOW(a_lower_triangle, !solve_q && state_q != ST_IDLE, j_q <= i_q, "factor column beyond row")
	`CFF_ASSERT_NOW(a_k_bound, state_q == ST_DOT, k_q <= kmax, "dot product index overran")
	`CFF_ASSERT_NOW(a_fac_write_range, fac_we, !solve_q && (5'(i_q) < n_q), "factor written outside the run")
	`CFF_ASSERT_NEXT(a_run_start, load_acc && last, state_q == ST_BASE && i_q == 4'd0 && !solve_q, "run did not start at row zero")

endmodule

### dv/cholesky_factor_forward_solve_checker.sv
`timescale 1ns / 1ps
module cholesky_factor_forward_solve_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	input  logic               load_valid,
	input  logic               load_stall,
	input  logic               func,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] value,
	input  logic               last,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [3:0]         index,
	input  logic signed [31:0] solution,
	input  logic signed [31:0] log_det,
	input  logic [1:0]         status,
	input  logic               last_result,
	output int                 errors,
	output int                 pending,
	output int                 results_seen
);
	import cff_pkg::*;

	localparam int FRAC = 16;
	localparam longint LN2 = 11629080;

	typedef struct {
		logic [3:0]         index;
		logic signed [31:0] solution;
		logic signed [31:0] log_det;
		logic [1:0]         status;
		logic               last_result;
	} solve_item_t;

	solve_item_t solution_q[$];
	longint mat_mem[256];
	longint rhs_mem[16];
	longint l_mem[256];
	longint x_mem[16];
	logic [4:0] order_reg = 5'd16;

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
	end

	function automatic longint clamp32(input longint v, inout bit s);
		if (v > 64'sd2147483647) begin
			s = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			s = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// products floor toward minus infinity
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic longint qdiv(input longint num, input longint den, inout bit s);
		return clamp32((num * 65536) / den, s);
	endfunction

	function automatic longint int_sqrt(input longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(res);
	endfunction

	function automatic longint q_ln(input longint y);
		int p, b;
		longint unsigned m;
		longint frac, lg;
		p = 0;
		frac = 0;
		while (p < 30 && (longint'(y) >> (p + 1)) != 0)
			p++;
		m = longint'(y) << (30 - p);
		for (b = FRAC; b > 0; b--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | (64'sd1 << (b - 1));
			end
		end
		lg = (longint'(p) - FRAC) * 65536 + frac;
		return (lg * LN2) >>> 24;
	endfunction

	task automatic factor_and_solve();
		int n, i, j, k;
		bit s;
		longint acc, ld;
		solve_item_t r;
		s = 0;
		ld = 0;
		n = order_reg;
		if (n < 1) n = 1;
		if (n > 16) n = 16;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < i; j++) begin
				acc = mat_mem[i*16+j];
				for (k = 0; k < j; k++)
					acc -= qmul(l_mem[i*16+k], l_mem[j*16+k]);
				acc = clamp32(acc, s);
				l_mem[i*16+j] = qdiv(acc, l_mem[j*16+j], s);
			end
			acc = mat_mem[i*16+i];
			for (k = 0; k < i; k++)
				acc -= qmul(l_mem[i*16+k], l_mem[i*16+k]);
			if (acc <= 0) begin
				// not positive definite: one flagged item ends the run
				r.index = i[3:0];
				r.solution = 0;
				r.log_det = 0;
				r.status = STATUS_NPD;
				r.last_result = 1;
				solution_q.push_back(r);
				return;
			end
			acc = clamp32(acc, s);
			l_mem[i*16+i] = int_sqrt(longint'(acc) << FRAC);
		end
		for (i = 0; i < n; i++)
			ld += q_ln(l_mem[i*16+i]);
		ld = clamp32(ld, s);
		for (i = 0; i < n; i++) begin
			acc = rhs_mem[i];
			for (j = 0; j < i; j++)
				acc -= qmul(l_mem[i*16+j], x_mem[j]);
			acc = clamp32(acc, s);
			x_mem[i] = qdiv(acc, l_mem[i*16+i], s);
		end
		for (i = 0; i < n; i++) begin
			r.index = i[3:0];
			r.solution = x_mem[i][31:0];
			r.log_det = ld[31:0];
			r.status = s ? STATUS_SAT : STATUS_OK;
			r.last_result = (i + 1 == n);
			solution_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk) begin
		solve_item_t e;
		if (arst_n) begin
			if (cfg_we)
				order_reg = cfg_wdata;
			if (load_valid && !load_stall) begin
				if (!func)
					mat_mem[row*16+col] = value;
				else
					rhs_mem[row] = value;
				if (last)
					factor_and_solve();
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (solution_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item index %0d", index));
				end else begin
					e = solution_q.pop_front();
					if (index !== e.index)
						report_mismatch($sformatf("index %0d, want %0d", index, e.index));
					if (solution !== e.solution)
						report_mismatch($sformatf("solution[%0d] %0d, want %0d",
							e.index, solution, e.solution));
					if (log_det !== e.log_det)
						report_mismatch($sformatf("log_det[%0d] %0d, want %0d",
							e.index, log_det, e.log_det));
					if (status !== e.status)
						report_mismatch($sformatf("status[%0d] %0d, want %0d",
							e.index, status, e.status));
					if (last_result !== e.last_result)
						report_mismatch($sformatf("last_result[%0d] %0b, want %0b",
							e.index, last_result, e.last_result));
				end
			end
			pending = solution_q.size();
		end
	end

endmodule

### dv/cholesky_factor_forward_solve_tb.sv
`timescale 1ns / 1ps
module cholesky_factor_forward_solve_tb;
	import cff_pkg::*;

	localparam bit FUNC_MATRIX = 1'b0;
	localparam bit FUNC_RHS    = 1'b1;
	// cycles with no accepted item before the run is declared hung
	localparam int STALL_LIMIT = 200000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [4:0]         cfg_wdata = 0;
	logic               load_valid = 0;
	logic               load_stall;
	logic               func = 0;
	logic [3:0]         row = 0;
	logic [3:0]         col = 0;
	logic signed [31:0] value = 0;
	logic               last = 0;
	logic               result_valid;
	logic               result_stall = 0;
	logic [3:0]         index;
	logic signed [31:0] solution;
	logic signed [31:0] log_det;
	logic [1:0]         status;
	logic               last_result;

	int errors, pending, results_seen;
	int idle_pct = 0;   // sender gap probability, percent
	int stall_pct = 0;  // receiver stall probability, percent
	int items_sent = 0;
	int runs_done = 0;
	int quiet = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	cholesky_factor_forward_solve dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.load_valid(load_valid), .load_stall(load_stall), .func(func), .row(row),
		.col(col), .value(value), .last(last), .result_valid(result_valid),
		.result_stall(result_stall), .index(index), .solution(solution),
		.log_det(log_det), .status(status), .last_result(last_result)
	);

	cholesky_factor_forward_solve_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.load_valid(load_valid), .load_stall(load_stall), .func(func), .row(row),
		.col(col), .value(value), .last(last), .result_valid(result_valid),
		.result_stall(result_stall), .index(index), .solution(solution),
		.log_det(log_det), .status(status), .last_result(last_result),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	// receiver back-pressure, re-rolled every cycle
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	// hang detector: no item accepted on either channel for too long
	always @(posedge clk) begin
		if ((load_valid && !load_stall) || (result_valid && !result_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", quiet);
			$display("Verification failed");
			$finish;
		end
	end

	// one load item; valid held with steady payload until accepted
	task automatic send_item(input bit f, input int r, input int c,
			input logic [31:0] v, input bit l);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			load_valid <= 0;
		end
		@(negedge clk);
		load_valid <= 1;
		func <= f;
		row <= r[3:0];
		col <= c[3:0];
		value <= v;
		last <= l;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = !load_stall;
		end
		items_sent++;
		// drop valid unless the next call raises it at this same negedge
		fork
			begin
				@(negedge clk);
				#0.1;
			end
		join_none
		load_valid <= 0;
	endtask

	// order register only changes once all results are in and the block is quiet
	task automatic set_order(input logic [4:0] n);
		@(negedge clk);
		load_valid <= 0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// kind: 0 well-conditioned, 1 random diagonal (often not positive definite),
	// 2 full-range values (saturation)
	task automatic solve_run(input logic [4:0] cfg, input int kind);
		int n, i, j;
		logic [31:0] v;
		n = (cfg == 0) ? 1 : (cfg > 16 ? 16 : cfg);
		set_order(cfg);
		for (i = 0; i < n; i++) begin
			for (j = 0; j <= i; j++) begin
				if (kind == 2)
					v = $urandom;
				else if (i == j && kind == 1)
					v = $urandom;
				else if (i == j)
					v = n * 65536 + $urandom_range(1 << 20);
				else
					v = $urandom_range(65536) - 32768;
				send_item(FUNC_MATRIX, i, j, v, 0);
			end
		end
		for (i = 0; i < n; i++)
			send_item(FUNC_RHS, i, $urandom_range(15), $urandom, i == n - 1);
		runs_done++;
	endtask

	initial begin
		int phase, k;
		logic [4:0] cfg;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: order 0 acts as 1, extreme diagonal and rhs
		set_order(5'd0);
		send_item(FUNC_MATRIX, 0, 0, 32'h7FFF_FFFF, 0);
		send_item(FUNC_RHS, 0, 0, 32'h8000_0000, 1);
		// negative pivot at the first row
		send_item(FUNC_MATRIX, 0, 0, 32'h8000_0000, 1);
		// zero pivot on the second row
		set_order(5'd2);
		send_item(FUNC_MATRIX, 0, 0, 32'h0001_0000, 0);
		send_item(FUNC_MATRIX, 1, 0, 32'h0001_0000, 0);
		send_item(FUNC_MATRIX, 1, 1, 32'h0001_0000, 0);
		send_item(FUNC_RHS, 0, 15, 32'h7FFF_FFFF, 0);
		send_item(FUNC_RHS, 1, 0, 32'hFFFF_FFFF, 1);
		// tiny pivot, huge off-diagonal: quotients saturate
		send_item(FUNC_MATRIX, 0, 0, 32'h0000_0001, 0);
		send_item(FUNC_MATRIX, 1, 0, 32'h7FFF_FFFF, 0);
		send_item(FUNC_MATRIX, 1, 1, 32'h7FFF_FFFF, 0);
		send_item(FUNC_RHS, 0, 0, 32'h0001_0000, 1);
		// stray writes, in the upper triangle or overwritten by the next run, are never read
		send_item(FUNC_MATRIX, 0, 15, 32'h5555_5555, 0);
		send_item(FUNC_MATRIX, 15, 15, 32'hAAAA_AAAA, 0);
		send_item(FUNC_RHS, 15, 15, 32'h0000_0000, 0);
		solve_run(5'd31, 0);  // above range acts as 16

		// random: cycle through the idle patterns
		phase = 0;
		while (items_sent < 380) begin
			case (phase % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 50; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 50; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			for (k = 0; k < 4; k++) begin
				cfg = ($urandom_range(9) == 0) ? 5'($urandom_range(16, 31))
					: 5'($urandom_range(0, 5));
				// noise writes between runs
				if ($urandom_range(3) == 0)
					send_item($urandom_range(1), $urandom_range(15),
						$urandom_range(15), $urandom, 0);
				case ($urandom_range(7))
					0: solve_run(cfg, 1);
					1: solve_run(cfg, 2);
					default: solve_run(cfg, 0);
				endcase
			end
			phase++;
		end
		solve_run(5'd16, 0);

		@(negedge clk);
		load_valid <= 0;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d solve runs, %0d load items, %0d results checked",
			runs_done, items_sent, results_seen);
		$display("orders 0..31 incl. extremes, pivot failures, saturation, four idle patterns");
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
